[src/indexed_min_heap_queue_unit_assert.svh]
// Assertion helpers for the indexed min-heap queue.
// Both macros clock on clk and are disabled while arst_n is low.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// Checks that an expression holds at every clock edge.
`define IMHQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that when ante holds, cons holds in the next cycle.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/imhq_pkg.sv]
package imhq_pkg;
	localparam int CAPACITY = 256;
	localparam int ADDR_W   = 8;
	localparam int ID_W     = 8;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 9;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;
endpackage

[src/imhq_ram.sv]
// simple dual-port RAM, one write port, one registered read port
module imhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[src/indexed_min_heap_queue_unit.sv]
// Indexed binary min-heap priority queue. Each request pushes an (id, key)
// entry, pops the minimum, or changes the key of a present id in place; every
// request yields one result with the removed entry, the new root, the count
// and a status. The heap slots live in a 40-bit entry RAM and the slot of
// each id in a position RAM, both with a registered read; presence
// of each id is kept in 256 flops cleared at reset, so no clearing pass runs.
// Sifts move a hole rather than swapping: the moving entry is held in a
// register and only written once it settles. One request is handled at a
// time, paced by the single read port of the entry RAM. A push climbs
// from the new last slot toward the root; a pop reads the root and the
// last entry, then sinks the last entry from the root unless the heap ends
// up empty; an update looks up the slot of the id, compares with the
// parent when that slot is not the root, then runs the matching sift;
// error and unused codes skip straight to the result. Every request ends
// by reading the root for the result, unless the heap is empty. Results
// sit in an output register, so the next request is taken while the last
// result still waits downstream; a second result then holds in the final
// state until it drains.
module indexed_min_heap_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] operation, [9:2] entry_id, [41:10] priority_req, rest zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] removed_id, [39:8] removed_priority, [47:40] top_id,
	// [79:48] top_priority, [88:80] entry_count, [89] is_empty,
	// [92:90] status, [95:93] zero
	output logic [95:0] m_tdata
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_UP0  = 4'd1;   // issue parent read
	localparam logic [3:0] S_UP1  = 4'd2;   // compare with parent
	localparam logic [3:0] S_POP0 = 4'd3;   // read root
	localparam logic [3:0] S_POP1 = 4'd4;   // root back, read last
	localparam logic [3:0] S_POP2 = 4'd5;   // last back
	localparam logic [3:0] S_UPD0 = 4'd6;   // read position
	localparam logic [3:0] S_UPD1 = 4'd7;   // position back
	localparam logic [3:0] S_UPD2 = 4'd8;   // parent back, pick direction
	localparam logic [3:0] S_DN0  = 4'd9;   // read left child
	localparam logic [3:0] S_DN1  = 4'd10;  // left back, read right
	localparam logic [3:0] S_DN2  = 4'd11;  // right back, pick child
	localparam logic [3:0] S_TOP0 = 4'd12;  // read root for the result
	localparam logic [3:0] S_TOP1 = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;  // hand result to output reg

	localparam int AW = imhq_pkg::ADDR_W;
	localparam int CW = imhq_pkg::CNT_W;

	logic [3:0]                    state_q;
	logic [CW-1:0]                 count_q;
	logic [AW-1:0]                 at_q;
	imhq_pkg::entry_t              cur_q;
	imhq_pkg::entry_t              left_q;
	imhq_pkg::entry_t              rem_q;
	imhq_pkg::entry_t              top_q;
	logic [2:0]                    status_q;
	logic [imhq_pkg::CAPACITY-1:0] present_q;
	logic                          m_valid_q;
	logic [95:0]                   m_data_q;

	// request fields
	logic [1:0]                    in_op;
	logic [imhq_pkg::ID_W-1:0]     in_id;
	logic [imhq_pkg::KEY_W-1:0]    in_key;
	logic                          in_acc;

	// memory ports
	logic                          heap_we;
	logic [AW-1:0]                 heap_waddr;
	imhq_pkg::entry_t              heap_wdata;
	logic [AW-1:0]                 heap_raddr;
	imhq_pkg::entry_t              heap_rdata;
	logic                          pos_we;
	logic [AW-1:0]                 pos_waddr;
	logic [AW-1:0]                 pos_wdata;
	logic [AW-1:0]                 pos_raddr;
	logic [AW-1:0]                 pos_rdata;

	// index arithmetic
	logic [AW-1:0]                 up_idx;
	logic [AW-1:0]                 upd_parent;
	logic [CW:0]                   left_idx;
	logic [CW:0]                   right_idx;
	logic                          right_ok;
	imhq_pkg::entry_t              pick;
	logic [AW-1:0]                 pick_idx;
	logic                          out_load;

	assign in_op    = s_tdata[1:0];
	assign in_id    = s_tdata[9:2];
	assign in_key   = s_tdata[41:10];
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign up_idx     = (at_q - AW'(1)) >> 1;
	assign upd_parent = (pos_rdata - AW'(1)) >> 1;
	assign left_idx   = {1'b0, at_q, 1'b1};
	assign right_idx  = left_idx + (CW+1)'(1);
	assign right_ok   = right_idx < (CW+1)'(count_q);

	// left wins ties
	always_comb begin
		if (!right_ok || left_q.key <= heap_rdata.key) begin
			pick     = left_q;
			pick_idx = left_idx[AW-1:0];
		end else begin
			pick     = heap_rdata;
			pick_idx = right_idx[AW-1:0];
		end
	end

	assign out_load = (state_q == S_FIN) && (!m_valid_q || m_tready);

	// memory port control
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = at_q;
		heap_wdata = cur_q;
		heap_raddr = '0;
		pos_we     = 1'b0;
		pos_waddr  = cur_q.id;
		pos_wdata  = at_q;
		pos_raddr  = cur_q.id;
		unique case (state_q)
			S_UP0: begin
				if (at_q == '0) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end else begin
					heap_raddr = up_idx;
				end
			end
			S_UP1, S_UPD2: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (heap_rdata.key > cur_q.key) begin
					heap_wdata = heap_rdata;
					pos_waddr  = heap_rdata.id;
				end else if (state_q == S_UPD2) begin
					heap_we = 1'b0;
					pos_we  = 1'b0;
				end
			end
			S_POP1: heap_raddr = AW'(count_q - CW'(1));
			S_UPD1: heap_raddr = upd_parent;
			S_DN0: begin
				if (left_idx >= (CW+1)'(count_q)) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end else begin
					heap_raddr = left_idx[AW-1:0];
				end
			end
			S_DN1: heap_raddr = right_idx[AW-1:0];
			S_DN2: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (cur_q.key > pick.key) begin
					heap_wdata = pick;
					pos_waddr  = pick.id;
				end
			end
			default: begin
			end
		endcase
	end

	imhq_ram #(
		.WIDTH($bits(imhq_pkg::entry_t)),
		.DEPTH(imhq_pkg::CAPACITY)
	) u_heap_ram (
		.clk  (clk),
		.we   (heap_we),
		.waddr(heap_waddr),
		.wdata(heap_wdata),
		.raddr(heap_raddr),
		.rdata(heap_rdata)
	);

	imhq_ram #(
		.WIDTH(AW),
		.DEPTH(imhq_pkg::CAPACITY)
	) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			present_q <= '0;
			status_q  <= imhq_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						status_q <= imhq_pkg::ST_OK;
						state_q  <= S_TOP0;
						case (in_op)
							imhq_pkg::OP_PUSH: begin
								if (count_q >= CW'(imhq_pkg::CAPACITY)) begin
									status_q <= imhq_pkg::ST_FULL;
								end else if (present_q[in_id]) begin
									status_q <= imhq_pkg::ST_PRESENT;
								end else begin
									present_q[in_id] <= 1'b1;
									count_q          <= count_q + CW'(1);
									state_q          <= S_UP0;
								end
							end
							imhq_pkg::OP_POP: begin
								if (count_q == '0) begin
									status_q <= imhq_pkg::ST_EMPTY;
								end else begin
									state_q <= S_POP0;
								end
							end
							imhq_pkg::OP_UPDATE: begin
								if (!present_q[in_id]) begin
									status_q <= imhq_pkg::ST_ABSENT;
								end else begin
									state_q <= S_UPD0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_UP0: state_q <= (at_q == '0) ? S_TOP0 : S_UP1;
				S_UP1: state_q <= (heap_rdata.key > cur_q.key) ? S_UP0 : S_TOP0;
				S_POP0: state_q <= S_POP1;
				S_POP1: begin
					present_q[heap_rdata.id] <= 1'b0;
					state_q                  <= S_POP2;
				end
				S_POP2: begin
					count_q <= count_q - CW'(1);
					state_q <= (count_q == CW'(1)) ? S_TOP0 : S_DN0;
				end
				S_UPD0: state_q <= S_UPD1;
				S_UPD1: begin
					if (CW'(pos_rdata) >= count_q) begin
						state_q <= S_TOP0;
					end else if (pos_rdata == '0) begin
						state_q <= S_DN0;
					end else begin
						state_q <= S_UPD2;
					end
				end
				S_UPD2: state_q <= (heap_rdata.key > cur_q.key) ? S_UP0 : S_DN0;
				S_DN0: state_q <= (left_idx >= (CW+1)'(count_q)) ? S_TOP0 : S_DN1;
				S_DN1: state_q <= S_DN2;
				S_DN2: state_q <= (cur_q.key > pick.key) ? S_DN0 : S_TOP0;
				S_TOP0: state_q <= (count_q == '0) ? S_FIN : S_TOP1;
				S_TOP1: state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= '{key: in_key, id: in_id};
				at_q  <= count_q[AW-1:0];
				rem_q <= '0;
			end
			S_UP1, S_UPD2: begin
				if (heap_rdata.key > cur_q.key) begin
					at_q <= up_idx;
				end
			end
			S_POP1: rem_q <= heap_rdata;
			S_POP2: begin
				cur_q <= heap_rdata;
				at_q  <= '0;
			end
			S_UPD1: at_q <= pos_rdata;
			S_DN1: left_q <= heap_rdata;
			S_DN2: begin
				if (cur_q.key > pick.key) begin
					at_q <= pick_idx;
				end
			end
			S_TOP0: top_q <= '0;
			S_TOP1: top_q <= heap_rdata;
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {3'b000, status_q, (count_q == '0), count_q,
				top_q.key, top_q.id, rem_q.key, rem_q.id};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`include "indexed_min_heap_queue_unit_assert.svh"

	`IMHQ_ASSERT(a_count_range, count_q <= CW'(imhq_pkg::CAPACITY), "count above capacity")
	`IMHQ_ASSERT(a_no_write_idle, !(heap_we && state_q == S_IDLE), "RAM write while idle")
	`IMHQ_ASSERT_NEXT(a_load_valid, out_load, m_valid_q, "result not presented after load")
	`IMHQ_ASSERT_NEXT(a_count_step, state_q == S_IDLE && !in_acc, count_q == $past(count_q), "count moved without a request")
endmodule
